// ===== rtl/tll_pkg.sv =====
package tll_pkg;

  typedef enum logic [2:0] {
    KIND_EOF    = 3'd0,
    KIND_DEF    = 3'd1,
    KIND_EXTERN = 3'd2,
    KIND_IDENT  = 3'd3,
    KIND_NUMBER = 3'd4,
    KIND_CHAR   = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_COMMENT
  } mode_t;

  // keyword tracker codes, one per matched prefix
  localparam logic [3:0] TRK_NONE   = 4'd0;
  localparam logic [3:0] TRK_D      = 4'd1;
  localparam logic [3:0] TRK_DE     = 4'd2;
  localparam logic [3:0] TRK_DEF    = 4'd3;
  localparam logic [3:0] TRK_E      = 4'd4;
  localparam logic [3:0] TRK_EX     = 4'd5;
  localparam logic [3:0] TRK_EXT    = 4'd6;
  localparam logic [3:0] TRK_EXTE   = 4'd7;
  localparam logic [3:0] TRK_EXTER  = 4'd8;
  localparam logic [3:0] TRK_EXTERN = 4'd9;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5a;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7a;
  localparam logic [7:0] CH_LD    = 8'h64;
  localparam logic [7:0] CH_LE    = 8'h65;
  localparam logic [7:0] CH_LF_F  = 8'h66;
  localparam logic [7:0] CH_LN    = 8'h6e;
  localparam logic [7:0] CH_LR    = 8'h72;
  localparam logic [7:0] CH_LT    = 8'h74;
  localparam logic [7:0] CH_LX    = 8'h78;

  localparam logic [30:0] NUM_MAX = '1;

  localparam int FIFO_DEPTH = 4;

  typedef struct packed {
    logic       end_mark;
    logic [7:0] char_code;
  } item_t;

  typedef struct packed {
    kind_t       kind;
    logic [30:0] value;
    logic [15:0] len;
    logic [15:0] line;
    logic [15:0] col;
    logic        last;
  } token_t;

  // tokens produced by one request, first in order first
  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } emit_t;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic [3:0] track_next(logic [3:0] t, logic [7:0] c);
    logic [3:0] r;
    r = TRK_NONE;
    case (t)
      TRK_D:     r = (c == CH_LE)   ? TRK_DE     : TRK_NONE;
      TRK_DE:    r = (c == CH_LF_F) ? TRK_DEF    : TRK_NONE;
      TRK_E:     r = (c == CH_LX)   ? TRK_EX     : TRK_NONE;
      TRK_EX:    r = (c == CH_LT)   ? TRK_EXT    : TRK_NONE;
      TRK_EXT:   r = (c == CH_LE)   ? TRK_EXTE   : TRK_NONE;
      TRK_EXTE:  r = (c == CH_LR)   ? TRK_EXTER  : TRK_NONE;
      TRK_EXTER: r = (c == CH_LN)   ? TRK_EXTERN : TRK_NONE;
      default:   r = TRK_NONE;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/toy_language_lexer_core.sv =====
// toy language lexer, one source byte per request
//
// input channel: in_valid/in_ready carry char_code and end_mark; end_mark set
//   means end of input, and char_code is then ignored
// output channel: out_valid/out_ready carry one token per transfer; a request
//   gives zero, one or two tokens, last_of_run marks the final one of a request
// path: a request waits in the input register until the queue has room for two
//   tokens; it is then scanned and its first token is offered from the queue
// throughput: one request per cycle while the receiver keeps up; the output side
//   moves one token per cycle, so requests that give two tokens fill the
//   four-entry token queue and in_ready drops while fewer than two slots are free
// stall: a stalled receiver leaves tokens queued; the input register holds its
//   byte until the queue has room, so nothing is dropped or repeated
// reset: clears the scanner to idle, line 1, column 0, and empties the queue
module toy_language_lexer_core #(
  parameter int COUNTER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_code,
  input  logic        end_mark,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  token_kind,
  output logic [30:0] token_value,
  output logic [15:0] ident_length,
  output logic [15:0] line_number,
  output logic [15:0] column_number,
  output logic        last_of_run
);
  import tll_pkg::*;

  // input register
  logic   inq_valid;
  item_t  inq;

  logic   fire;
  logic   room2;
  logic   pop;
  emit_t  emit;
  emit_t  push;
  token_t head;

  // scan the held byte only when the queue can take two tokens
  assign fire     = inq_valid && room2;
  assign in_ready = !inq_valid || room2;
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      inq_valid <= 1'b1;
    end else if (fire) begin
      inq_valid <= 1'b0;
    end
  end

  // byte payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq.char_code <= char_code;
      inq.end_mark  <= end_mark;
    end
  end

  tll_scanner #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_scanner (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (inq),
    .emit (emit)
  );

  // tokens only enter the queue when the scanner actually advances
  always_comb begin
    push       = emit;
    push.count = fire ? emit.count : 2'd0;
  end

  tll_token_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .head      (head),
    .not_empty (out_valid),
    .room2     (room2)
  );

  assign token_kind    = head.kind;
  assign token_value   = head.value;
  assign ident_length  = head.len;
  assign line_number   = head.line;
  assign column_number = head.col;
  assign last_of_run   = head.last;

endmodule

// ===== rtl/tll_scanner.sv =====
module tll_scanner #(
  parameter int COUNTER_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  tll_pkg::item_t item,
  output tll_pkg::emit_t emit
);
  import tll_pkg::*;

  mode_t                   mode, mode_next;
  logic [3:0]              trk, trk_next;
  logic [30:0]             acc, acc_next;
  logic [COUNTER_BITS-1:0] len, len_next;
  logic [COUNTER_BITS-1:0] line, line_next;
  logic [COUNTER_BITS-1:0] col, col_next;

  logic [7:0]  c;
  logic        is_nl;
  logic        pend, fresh, rescan;
  kind_t       ident_kind;
  logic [34:0] acc_mul;
  logic [31:0] len_ext, line_ext, col_ext;
  token_t      pend_tok, fresh_tok;

  assign c     = item.char_code;
  assign is_nl = (c == CH_LF) || (c == CH_CR);

  // acc * 10 + digit, saturated to 31 bits
  assign acc_mul = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + 35'(c[3:0]);

  assign len_ext  = 32'(len);
  assign line_ext = 32'(line_next);
  assign col_ext  = 32'(col_next);

  always_comb begin
    priority if (trk == TRK_DEF) begin
      ident_kind = KIND_DEF;
    end else if (trk == TRK_EXTERN) begin
      ident_kind = KIND_EXTERN;
    end else begin
      ident_kind = KIND_IDENT;
    end
  end

  always_comb begin
    mode_next = mode;
    trk_next  = trk;
    acc_next  = acc;
    len_next  = len;
    line_next = line;
    col_next  = col;
    pend      = 1'b0;
    fresh     = 1'b0;
    rescan    = 1'b0;
    pend_tok  = '0;
    fresh_tok = '0;
    if (item.end_mark) begin
      if (mode == MODE_IDENT) begin
        pend          = 1'b1;
        pend_tok.kind = ident_kind;
        pend_tok.len  = len_ext[15:0];
      end else if (mode == MODE_NUMBER) begin
        pend           = 1'b1;
        pend_tok.kind  = KIND_NUMBER;
        pend_tok.value = acc;
      end
      fresh          = 1'b1;
      fresh_tok.kind = KIND_EOF;
      mode_next      = MODE_IDLE;
    end else begin
      if (is_nl) begin
        if (line != '1) line_next = line + 1'b1;
        col_next = '0;
      end else if (col != '1) begin
        col_next = col + 1'b1;
      end
      unique case (mode)
        MODE_IDENT: begin
          if (is_alpha(c) || is_digit(c)) begin
            trk_next = track_next(trk, c);
            if (len != '1) len_next = len + 1'b1;
          end else begin
            pend          = 1'b1;
            pend_tok.kind = ident_kind;
            pend_tok.len  = len_ext[15:0];
            rescan        = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (is_digit(c)) begin
            acc_next = (acc_mul > 35'(NUM_MAX)) ? NUM_MAX : acc_mul[30:0];
          end else begin
            pend           = 1'b1;
            pend_tok.kind  = KIND_NUMBER;
            pend_tok.value = acc;
            rescan         = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if (is_nl) mode_next = MODE_IDLE;
        end
        MODE_IDLE: begin
          rescan = 1'b1;
        end
      endcase
      if (rescan) begin
        mode_next = MODE_IDLE;
        priority if (is_space(c)) begin
          mode_next = MODE_IDLE;
        end else if (is_alpha(c)) begin
          mode_next = MODE_IDENT;
          trk_next  = (c == CH_LD) ? TRK_D : (c == CH_LE) ? TRK_E : TRK_NONE;
          len_next  = COUNTER_BITS'(1);
        end else if (is_digit(c)) begin
          mode_next = MODE_NUMBER;
          acc_next  = 31'(c[3:0]);
        end else if (c == CH_HASH) begin
          mode_next = MODE_COMMENT;
        end else begin
          fresh           = 1'b1;
          fresh_tok.kind  = KIND_CHAR;
          fresh_tok.value = 31'(c);
        end
      end
    end
    pend_tok.line  = line_ext[15:0];
    pend_tok.col   = col_ext[15:0];
    pend_tok.last  = !fresh;
    fresh_tok.line = line_ext[15:0];
    fresh_tok.col  = col_ext[15:0];
    fresh_tok.last = 1'b1;
  end

  always_comb begin
    emit.count  = 2'(pend) + 2'(fresh);
    emit.first  = pend ? pend_tok : fresh_tok;
    emit.second = fresh_tok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      trk  <= TRK_NONE;
      acc  <= '0;
      len  <= '0;
      line <= COUNTER_BITS'(1);
      col  <= '0;
    end else if (fire) begin
      mode <= mode_next;
      trk  <= trk_next;
      acc  <= acc_next;
      len  <= len_next;
      line <= line_next;
      col  <= col_next;
    end
  end

endmodule

// ===== rtl/tll_token_fifo.sv =====
module tll_token_fifo (
  input  logic            clk,
  input  logic            rst,
  input  tll_pkg::emit_t  push,
  input  logic            pop,
  output tll_pkg::token_t head,
  output logic            not_empty,
  output logic            room2
);
  import tll_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  token_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr, wr_ptr_inc;
  logic [CNT_W-1:0]   count;

  assign wr_ptr_inc = wr_ptr + 1'b1;
  assign head       = mem[rd_ptr];
  assign not_empty  = count != '0;
  assign room2      = count <= CNT_W'(FIFO_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count + CNT_W'(push.count) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wr_ptr] <= push.first;
    if (push.count == 2'd2) mem[wr_ptr_inc] <= push.second;
  end

endmodule

// ===== rtl/tll_checker.sv =====
module tll_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  char_code,
  input logic        end_mark,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  token_kind,
  input logic [30:0] token_value,
  input logic [15:0] ident_length,
  input logic [15:0] line_number,
  input logic [15:0] column_number,
  input logic        last_of_run
);
  import tll_pkg::*;

  // nothing comes out in the cycle after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("token offered right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(token_kind) && $stable(token_value)
      && $stable(last_of_run))
    else $error("token changed while stalled");

  // eof is always the final token of its request
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == KIND_EOF |-> last_of_run)
    else $error("eof token not marked last");

  // only numbers and characters carry a value, and eof carries no length
  a_field_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (token_kind == KIND_DEF || token_kind == KIND_EXTERN
      || token_kind == KIND_IDENT || token_kind == KIND_EOF)
      |-> token_value == '0 && (token_kind != KIND_EOF || ident_length == '0))
    else $error("unused token field not zero");

endmodule

bind toy_language_lexer_core tll_checker u_tll_checker (.*);

// ===== test/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tll_pkg::*;

  localparam int COUNTER_W   = 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_REQS = 950;
  localparam int SHOW_LIMIT  = 40;     // mismatch lines printed at most

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  char_code;
  logic        end_mark;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  token_kind;
  logic [30:0] token_value;
  logic [15:0] ident_length;
  logic [15:0] line_number;
  logic [15:0] column_number;
  logic        last_of_run;

  int requests_taken = 0;
  int burst_left = 0;

  // byte classes of the source language
  function automatic bit letter_byte(logic [7:0] c);
    return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
  endfunction

  function automatic bit digit_byte(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit blank_byte(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit line_break(logic [7:0] c);
    return c == CH_LF || c == CH_CR;
  endfunction

  // scanner mirror plus the queue of tokens still owed by the block
  class lexer_scoreboard;
    mode_t       mode;
    logic [3:0]  keyword;
    logic [30:0] number;
    logic [15:0] word_len;
    logic [15:0] line;
    logic [15:0] col;
    token_t      owed_tokens[$];
    int          errors;

    function new();
      mode     = MODE_IDLE;
      keyword  = TRK_NONE;
      number   = '0;
      word_len = '0;
      line     = 16'd1;
      col      = '0;
      errors   = 0;
    endfunction

    // advance the def / extern prefix match by one byte
    function logic [3:0] keyword_step(logic [3:0] t, logic [7:0] c);
      logic [7:0] want;
      logic [3:0] nxt;
      case (t)
        TRK_D: begin
          want = CH_LE;
          nxt  = TRK_DE;
        end
        TRK_DE: begin
          want = CH_LF_F;
          nxt  = TRK_DEF;
        end
        TRK_E: begin
          want = CH_LX;
          nxt  = TRK_EX;
        end
        TRK_EX: begin
          want = CH_LT;
          nxt  = TRK_EXT;
        end
        TRK_EXT: begin
          want = CH_LE;
          nxt  = TRK_EXTE;
        end
        TRK_EXTE: begin
          want = CH_LR;
          nxt  = TRK_EXTER;
        end
        TRK_EXTER: begin
          want = CH_LN;
          nxt  = TRK_EXTERN;
        end
        default: return TRK_NONE;
      endcase
      return (c == want) ? nxt : TRK_NONE;
    endfunction

    function void owe(kind_t kind, logic [30:0] value, logic [15:0] len);
      token_t tok;
      tok.kind  = kind;
      tok.value = value;
      tok.len   = len;
      tok.line  = line;
      tok.col   = col;
      tok.last  = 1'b0;
      owed_tokens.push_back(tok);
    endfunction

    function void owe_word();
      if (keyword == TRK_DEF) owe(KIND_DEF, '0, word_len);
      else if (keyword == TRK_EXTERN) owe(KIND_EXTERN, '0, word_len);
      else owe(KIND_IDENT, '0, word_len);
    endfunction

    function void note_request(logic [7:0] c, logic e);
      int               before_cnt;
      bit               rescan;
      longint unsigned  acc;
      token_t           tok;
      before_cnt = owed_tokens.size();
      if (e) begin
        if (mode == MODE_IDENT) owe_word();
        else if (mode == MODE_NUMBER) owe(KIND_NUMBER, number, '0);
        owe(KIND_EOF, '0, '0);
        mode = MODE_IDLE;
      end else begin
        if (line_break(c)) begin
          if (line != '1) line++;
          col = '0;
        end else if (col != '1) begin
          col++;
        end
        rescan = 1'b1;
        case (mode)
          MODE_IDENT: begin
            if (letter_byte(c) || digit_byte(c)) begin
              keyword = keyword_step(keyword, c);
              if (word_len != '1) word_len++;
              rescan = 1'b0;
            end else begin
              owe_word();
              mode = MODE_IDLE;
            end
          end
          MODE_NUMBER: begin
            if (digit_byte(c)) begin
              acc = number;
              acc = acc * 10 + (c - CH_ZERO);
              number = (acc > NUM_MAX) ? NUM_MAX : acc[30:0];
              rescan = 1'b0;
            end else begin
              owe(KIND_NUMBER, number, '0);
              mode = MODE_IDLE;
            end
          end
          MODE_COMMENT: begin
            if (line_break(c)) mode = MODE_IDLE;
            rescan = 1'b0;
          end
          default: ;
        endcase
        if (rescan) begin
          if (blank_byte(c)) begin
          end else if (letter_byte(c)) begin
            mode     = MODE_IDENT;
            keyword  = (c == CH_LD) ? TRK_D : (c == CH_LE) ? TRK_E : TRK_NONE;
            word_len = 16'd1;
          end else if (digit_byte(c)) begin
            mode   = MODE_NUMBER;
            number = c - CH_ZERO;
          end else if (c == CH_HASH) begin
            mode = MODE_COMMENT;
          end else begin
            owe(KIND_CHAR, {23'd0, c}, '0);
          end
        end
      end
      if (owed_tokens.size() > before_cnt) begin
        tok = owed_tokens.pop_back();
        tok.last = 1'b1;
        owed_tokens.push_back(tok);
      end
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= SHOW_LIMIT)
          $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_token(logic [2:0] kind, logic [30:0] value, logic [15:0] len,
                              logic [15:0] ln, logic [15:0] cl, logic last);
      token_t want;
      if (owed_tokens.size() == 0) begin
        errors++;
        if (errors <= SHOW_LIMIT)
          $display("%0t: token with none expected: expected none, actual kind %0d value %0d",
                   $time, kind, value);
        return;
      end
      want = owed_tokens.pop_front();
      compare_field("token_kind", want.kind, kind);
      compare_field("token_value", want.value, value);
      compare_field("ident_length", want.len, len);
      compare_field("line_number", want.line, ln);
      compare_field("column_number", want.col, cl);
      compare_field("last_of_run", want.last, last);
    endfunction
  endclass

  lexer_scoreboard sb;

  toy_language_lexer_core #(
    .COUNTER_BITS(COUNTER_W)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .char_code     (char_code),
    .end_mark      (end_mark),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .token_kind    (token_kind),
    .token_value   (token_value),
    .ident_length  (ident_length),
    .line_number   (line_number),
    .column_number (column_number),
    .last_of_run   (last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one request on the input channel; bursts of random length with random gaps
  task automatic offer(input logic [7:0] c, input logic e);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 7);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    if (burst_left != 0) burst_left--;
    in_valid  <= 1'b1;
    char_code <= c;
    end_mark  <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(c, e);
    requests_taken++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) offer(s[i], 1'b0);
  endtask

  // end mark; the byte beside it is random since the block ignores it
  task automatic send_end();
    offer(8'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic logic [7:0] random_alnum();
    int r;
    r = $urandom_range(0, 61);
    if (r < 10) return CH_ZERO + 8'(r);
    if (r < 36) return CH_UA + 8'(r - 10);
    return CH_LA + 8'(r - 36);
  endfunction

  function automatic logic [7:0] random_blank();
    return ($urandom_range(0, 2) == 0) ? CH_SPACE : CH_TAB + 8'($urandom_range(0, 4));
  endfunction

  // a byte that lexes as a character token
  function automatic logic [7:0] random_other();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (letter_byte(b) || digit_byte(b) || blank_byte(b) || b == CH_HASH);
    return b;
  endfunction

  // one well-formed fragment of source, sometimes noise or a broken sequence
  task automatic random_piece();
    string words[10];
    logic [7:0] b;
    int n;
    words = '{"def", "extern", "de", "ext", "define", "externs", "d", "e", "exter", "xdef"};
    case ($urandom_range(0, 9))
      0, 1: begin
        if ($urandom_range(0, 1) == 0) begin
          send_text(words[$urandom_range(0, 9)]);
        end else begin
          offer(($urandom_range(0, 1) == 0) ? CH_LA + 8'($urandom_range(0, 25))
                                            : CH_UA + 8'($urandom_range(0, 25)), 1'b0);
          repeat ($urandom_range(0, 9)) offer(random_alnum(), 1'b0);
        end
      end
      2, 3: begin
        // long runs push the number into saturation
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 13) : $urandom_range(1, 5);
        repeat (n) offer(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
      end
      4: offer(random_blank(), 1'b0);
      5: offer(random_other(), 1'b0);
      6: begin
        offer(CH_HASH, 1'b0);
        repeat ($urandom_range(0, 8)) begin
          do b = 8'($urandom_range(0, 255));
          while (line_break(b));
          offer(b, 1'b0);
        end
        if ($urandom_range(0, 5) == 0) send_end();
        else offer(($urandom_range(0, 1) == 0) ? CH_LF : CH_CR, 1'b0);
      end
      7: send_end();
      default: offer(8'($urandom_range(0, 255)), 1'b0);
    endcase
    // separator: none, blank or character token right after the fragment
    case ($urandom_range(0, 3))
      0: ;
      1: offer(random_other(), 1'b0);
      default: offer(random_blank(), 1'b0);
    endcase
  endtask

  // main sequence: reset, directed tokens, random source
  initial begin : stimulus
    int base;
    sb = new();
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    char_code <= '0;
    end_mark  <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // keyword closed by a character: two tokens from one request
    send_text("def(");
    send_text("extern\n");
    // number closed by a comment, comment closed by carriage return
    send_text("42#z\r");
    // byte extremes as character tokens
    offer(8'h00, 1'b0);
    offer(8'hff, 1'b0);
    // pending number then eof, repeated eof, pending word then eof
    send_text("7");
    send_end();
    send_end();
    send_text("ab");
    send_end();
    // end mark inside a comment
    send_text("#");
    send_end();

    base = requests_taken;
    while (requests_taken - base < RANDOM_REQS) random_piece();
    send_end();
    in_valid <= 1'b0;

    // drain the owed tokens, then watch a while for strays
    while (sb.owed_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.owed_tokens.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // receiver: random ready styles in segments, plus one long hold-off that
  // lets the token queue fill so in_ready drops while requests keep coming
  initial begin : receiver
    int  style;
    int  span;
    int  held_cycles;
    bit  held;
    held = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      style = $urandom_range(0, 3);
      span  = $urandom_range(1, 50);
      if (!held && requests_taken >= 400) begin
        held = 1'b1;
        out_ready <= 1'b0;
        held_cycles = 0;
        while (held_cycles < 300) begin
          @(posedge clk);
          held_cycles++;
        end
      end
      repeat (span) begin
        case (style)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 9) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // token monitor, sampled at the edge where the transfer happens
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_token(token_kind, token_value, ident_length, line_number, column_number,
                     last_of_run);
  end

  // run limit, far above the slowest correct run
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== toy_language_lexer_core.f =====
rtl/tll_pkg.sv
rtl/tll_scanner.sv
rtl/tll_token_fifo.sv
rtl/toy_language_lexer_core.sv
rtl/tll_checker.sv
test/tb_top.sv
